/* rtl/assert_macros.svh */
// Assertion macros for the checker file of this project.
// Needs nothing else; a file includes it before it asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, switched off while reset is high.
`define CCSPMV_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ccspmv assertion failed");

// Concurrent assertion that also holds across reset.
`define CCSPMV_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("ccspmv assertion failed");

`endif

/* rtl/ccspmv_pkg.sv */
// Types, command codes and constants of the complex CSR SpMV accumulator.
// Used by the channel interfaces, every module and the checker.
`default_nettype none

package ccspmv_pkg;

   typedef logic [1:0]          cmd_type;
   typedef logic [9:0]          index_type;
   typedef logic signed [31:0]  word_type;
   typedef logic signed [47:0]  acc_type;
   typedef logic [0:0]          csr_index_type;

   localparam cmd_type CMD_LOAD    = 2'd0;
   localparam cmd_type CMD_NONZERO = 2'd1;
   localparam cmd_type CMD_END_ROW = 2'd2;

   localparam csr_index_type CSR_SCALE_RE = 1'b0;
   localparam csr_index_type CSR_SCALE_IM = 1'b1;

   localparam word_type SCALE_RE_RESET = 32'sh0001_0000;
   localparam word_type SCALE_IM_RESET = 32'sh0000_0000;

   localparam word_type WORD_MAX = 32'sh7FFF_FFFF;
   localparam word_type WORD_MIN = 32'sh8000_0000;

   // Result queue depth, a power of two above the end-row latency.
   localparam int RSP_DEPTH = 16;

   // Item leaving the vector store stage.
   typedef struct packed {
      logic     nonzero;
      logic     end_row;
      logic     zero_x;
      word_type value_re;
      word_type value_im;
   } op_type;

   // End-of-row item with its accumulator snapshot.
   typedef struct packed {
      logic     valid;
      acc_type  acc_re;
      acc_type  acc_im;
      word_type old_re;
      word_type old_im;
   } row_type;

   typedef struct packed {
      word_type result_re;
      word_type result_im;
      logic     saturated;
   } result_type;

endpackage

`default_nettype wire

/* rtl/ccspmv_if.sv */
// Valid/ready channel interfaces for request and response items.
// Depends on ccspmv_pkg for the payload types.
`default_nettype none

interface ccspmv_req_if;
   import ccspmv_pkg::*;

   logic      valid;
   logic      ready;
   cmd_type   cmd;
   index_type index;
   word_type  value_re;
   word_type  value_im;

   modport source (output valid, output cmd, output index, output value_re,
                   output value_im, input ready);
   modport sink   (input valid, input cmd, input index, input value_re,
                   input value_im, output ready);
endinterface

interface ccspmv_rsp_if;
   import ccspmv_pkg::*;

   logic     valid;
   logic     ready;
   word_type result_re;
   word_type result_im;
   logic     saturated;

   modport source (output valid, output result_re, output result_im,
                   output saturated, input ready);
   modport sink   (input valid, input result_re, input result_im,
                   input saturated, output ready);
endinterface

`default_nettype wire

/* rtl/complex_csr_spmv_accumulate.sv */
// Channel  Dir  Payload                                  Accept
// req_bus  in   cmd, index, value_re, value_im           valid && ready
// rsp_bus  out  result_re, result_im, saturated          valid && ready
// csr_*    in   csr_index, csr_wdata (scale_re/scale_im) csr_write_en
//
// One item per cycle of any kind while req_bus.ready is high; an end-row
// result becomes visible after the store read at the accepting edge, then two
// multiply/truncate stages, accumulator, three scale stages and the result queue.
// Synchronous reset clears control, the accumulator and the scale factor;
// the vector store has no clearing pass and reads undefined until loaded.
// req_bus.ready falls only when 16 end-row results are queued or in flight.
// Top level of the complex CSR SpMV accumulator. Depends on ccspmv_pkg,
// the channel interfaces and the vstore, acc, scale and fifo modules.
`default_nettype none

module complex_csr_spmv_accumulate #(
   parameter int VECTOR_DEPTH = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   ccspmv_req_if.sink                req_bus,
   ccspmv_rsp_if.source              rsp_bus,
   input  logic                      csr_write_en,
   input  ccspmv_pkg::csr_index_type csr_index,
   input  ccspmv_pkg::word_type      csr_wdata
);
   import ccspmv_pkg::*;

   logic       accept;
   logic       claim;
   logic       space;
   logic       push;
   logic       rsp_valid;
   word_type   scale_re_ff;
   word_type   scale_im_ff;
   op_type     op;
   word_type   vec_re;
   word_type   vec_im;
   row_type    row;
   result_type result;
   result_type head;

   assign accept        = req_bus.valid && req_bus.ready;
   assign claim         = accept && req_bus.cmd == CMD_END_ROW;
   assign req_bus.ready = space;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_re_ff <= SCALE_RE_RESET;
         scale_im_ff <= SCALE_IM_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SCALE_RE: scale_re_ff <= csr_wdata;
            CSR_SCALE_IM: scale_im_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   ccspmv_vstore #(
      .VECTOR_DEPTH (VECTOR_DEPTH)
   ) u_vstore (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .cmd      (req_bus.cmd),
      .index    (req_bus.index),
      .value_re (req_bus.value_re),
      .value_im (req_bus.value_im),
      .op       (op),
      .vec_re   (vec_re),
      .vec_im   (vec_im)
   );

   ccspmv_acc u_acc (
      .clock  (clock),
      .reset  (reset),
      .op     (op),
      .vec_re (vec_re),
      .vec_im (vec_im),
      .row    (row)
   );

   ccspmv_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .row      (row),
      .scale_re (scale_re_ff),
      .scale_im (scale_im_ff),
      .push     (push),
      .result   (result)
   );

   ccspmv_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .claim     (claim),
      .push      (push),
      .push_data (result),
      .pop       (rsp_bus.ready),
      .space     (space),
      .valid     (rsp_valid),
      .head      (head)
   );

   assign rsp_bus.valid     = rsp_valid;
   assign rsp_bus.result_re = head.result_re;
   assign rsp_bus.result_im = head.result_im;
   assign rsp_bus.saturated = head.saturated;

endmodule

`default_nettype wire

/* rtl/ccspmv_vstore.sv */
// Dense vector store: one synchronous memory, written by load items and
// read for nonzero items. Depends on ccspmv_pkg.
`default_nettype none

module ccspmv_vstore #(
   parameter int VECTOR_DEPTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  ccspmv_pkg::cmd_type   cmd,
   input  ccspmv_pkg::index_type index,
   input  ccspmv_pkg::word_type  value_re,
   input  ccspmv_pkg::word_type  value_im,
   output ccspmv_pkg::op_type    op,
   output ccspmv_pkg::word_type  vec_re,
   output ccspmv_pkg::word_type  vec_im
);
   import ccspmv_pkg::*;

   localparam int          ADDR_W      = $clog2(VECTOR_DEPTH);
   localparam logic [16:0] DEPTH_LIMIT = 17'(VECTOR_DEPTH);

   logic [63:0]       mem [VECTOR_DEPTH];
   logic [63:0]       rd_data_ff;
   logic [16:0]       index_wide;
   logic [ADDR_W-1:0] addr;
   logic              in_range;

   logic     nonzero_ff;
   logic     end_row_ff;
   logic     zero_x_ff;
   word_type value_re_ff;
   word_type value_im_ff;

   assign index_wide = 17'(index);
   assign in_range   = index_wide < DEPTH_LIMIT;
   assign addr       = index_wide[ADDR_W-1:0];

   // A load writes at its own accept edge, so the next item already reads it.
   always_ff @(posedge clock) begin
      if (accept && cmd == CMD_LOAD && in_range) begin
         mem[addr] <= {value_im, value_re};
      end
      rd_data_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nonzero_ff <= 1'b0;
         end_row_ff <= 1'b0;
      end else begin
         nonzero_ff <= accept && cmd == CMD_NONZERO;
         end_row_ff <= accept && cmd == CMD_END_ROW;
      end
   end

   always_ff @(posedge clock) begin
      zero_x_ff   <= !in_range;
      value_re_ff <= value_re;
      value_im_ff <= value_im;
   end

   assign op = '{nonzero:  nonzero_ff,
                 end_row:  end_row_ff,
                 zero_x:   zero_x_ff,
                 value_re: value_re_ff,
                 value_im: value_im_ff};

   assign vec_re = rd_data_ff[31:0];
   assign vec_im = rd_data_ff[63:32];

endmodule

`default_nettype wire

/* rtl/ccspmv_acc.sv */
// Complex multiply of matrix value by vector entry and the 48-bit
// accumulator; snapshots and clears it on end of row. Depends on ccspmv_pkg.
`default_nettype none

module ccspmv_acc (
   input  logic                 clock,
   input  logic                 reset,
   input  ccspmv_pkg::op_type   op,
   input  ccspmv_pkg::word_type vec_re,
   input  ccspmv_pkg::word_type vec_im,
   output ccspmv_pkg::row_type  row
);
   import ccspmv_pkg::*;

   word_type x_re;
   word_type x_im;

   logic               s2_nonzero_ff;
   logic               s2_end_row_ff;
   logic signed [63:0] p_rr_ff;
   logic signed [63:0] p_ii_ff;
   logic signed [63:0] p_ri_ff;
   logic signed [63:0] p_ir_ff;
   word_type           s2_old_re_ff;
   word_type           s2_old_im_ff;

   logic     s3_nonzero_ff;
   logic     s3_end_row_ff;
   acc_type  prod_re_ff;
   acc_type  prod_im_ff;
   word_type s3_old_re_ff;
   word_type s3_old_im_ff;

   acc_type  acc_re_ff;
   acc_type  acc_im_ff;
   logic     row_valid_ff;
   acc_type  row_acc_re_ff;
   acc_type  row_acc_im_ff;
   word_type row_old_re_ff;
   word_type row_old_im_ff;

   // Column beyond the store contributes nothing.
   assign x_re = op.zero_x ? '0 : vec_re;
   assign x_im = op.zero_x ? '0 : vec_im;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_nonzero_ff <= 1'b0;
         s2_end_row_ff <= 1'b0;
         s3_nonzero_ff <= 1'b0;
         s3_end_row_ff <= 1'b0;
      end else begin
         s2_nonzero_ff <= op.nonzero;
         s2_end_row_ff <= op.end_row;
         s3_nonzero_ff <= s2_nonzero_ff;
         s3_end_row_ff <= s2_end_row_ff;
      end
   end

   always_ff @(posedge clock) begin
      p_rr_ff      <= 64'(op.value_re) * 64'(x_re);
      p_ii_ff      <= 64'(op.value_im) * 64'(x_im);
      p_ri_ff      <= 64'(op.value_re) * 64'(x_im);
      p_ir_ff      <= 64'(op.value_im) * 64'(x_re);
      s2_old_re_ff <= op.value_re;
      s2_old_im_ff <= op.value_im;

      // Truncate each product on its own; the sum wraps at 48 bits anyway.
      prod_re_ff   <= p_rr_ff[63:16] - p_ii_ff[63:16];
      prod_im_ff   <= p_ri_ff[63:16] + p_ir_ff[63:16];
      s3_old_re_ff <= s2_old_re_ff;
      s3_old_im_ff <= s2_old_im_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_re_ff    <= '0;
         acc_im_ff    <= '0;
         row_valid_ff <= 1'b0;
      end else begin
         row_valid_ff <= s3_end_row_ff;
         if (s3_end_row_ff) begin
            acc_re_ff <= '0;
            acc_im_ff <= '0;
         end else if (s3_nonzero_ff) begin
            acc_re_ff <= acc_re_ff + prod_re_ff;
            acc_im_ff <= acc_im_ff + prod_im_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      row_acc_re_ff <= acc_re_ff;
      row_acc_im_ff <= acc_im_ff;
      row_old_re_ff <= s3_old_re_ff;
      row_old_im_ff <= s3_old_im_ff;
   end

   assign row = '{valid:  row_valid_ff,
                  acc_re: row_acc_re_ff,
                  acc_im: row_acc_im_ff,
                  old_re: row_old_re_ff,
                  old_im: row_old_im_ff};

endmodule

`default_nettype wire

/* rtl/ccspmv_scale.sv */
// End-of-row pipeline: old + a*acc with per-product truncation, then a
// clamp to 32 bits with a flag. Depends on ccspmv_pkg.
`default_nettype none

module ccspmv_scale (
   input  logic                   clock,
   input  logic                   reset,
   input  ccspmv_pkg::row_type    row,
   input  ccspmv_pkg::word_type   scale_re,
   input  ccspmv_pkg::word_type   scale_im,
   output logic                   push,
   output ccspmv_pkg::result_type result
);
   import ccspmv_pkg::*;

   localparam logic signed [66:0] SUM_MAX = 67'(WORD_MAX);
   localparam logic signed [66:0] SUM_MIN = 67'(WORD_MIN);

   // Accumulator split into signed high word and unsigned low 16 bits.
   word_type           hi_re;
   word_type           hi_im;
   logic signed [16:0] lo_re;
   logic signed [16:0] lo_im;

   logic               e1_valid_ff;
   logic signed [63:0] ar_hr_ff;
   logic signed [63:0] ai_hi_ff;
   logic signed [63:0] ar_hi_ff;
   logic signed [63:0] ai_hr_ff;
   logic signed [48:0] ar_lr_ff;
   logic signed [48:0] ai_li_ff;
   logic signed [48:0] ar_li_ff;
   logic signed [48:0] ai_lr_ff;
   word_type           e1_old_re_ff;
   word_type           e1_old_im_ff;

   logic               e2_valid_ff;
   logic signed [64:0] m_rr_ff;
   logic signed [64:0] m_ii_ff;
   logic signed [64:0] m_ri_ff;
   logic signed [64:0] m_ir_ff;
   word_type           e2_old_re_ff;
   word_type           e2_old_im_ff;

   logic               e3_valid_ff;
   logic signed [66:0] sum_re_ff;
   logic signed [66:0] sum_im_ff;

   logic over_re;
   logic under_re;
   logic over_im;
   logic under_im;

   assign hi_re = row.acc_re[47:16];
   assign hi_im = row.acc_im[47:16];
   assign lo_re = {1'b0, row.acc_re[15:0]};
   assign lo_im = {1'b0, row.acc_im[15:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
         e2_valid_ff <= 1'b0;
         e3_valid_ff <= 1'b0;
      end else begin
         e1_valid_ff <= row.valid;
         e2_valid_ff <= e1_valid_ff;
         e3_valid_ff <= e2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      ar_hr_ff     <= 64'(scale_re) * 64'(hi_re);
      ar_lr_ff     <= 49'(scale_re) * 49'(lo_re);
      ai_hi_ff     <= 64'(scale_im) * 64'(hi_im);
      ai_li_ff     <= 49'(scale_im) * 49'(lo_im);
      ar_hi_ff     <= 64'(scale_re) * 64'(hi_im);
      ar_li_ff     <= 49'(scale_re) * 49'(lo_im);
      ai_hr_ff     <= 64'(scale_im) * 64'(hi_re);
      ai_lr_ff     <= 49'(scale_im) * 49'(lo_re);
      e1_old_re_ff <= row.old_re;
      e1_old_im_ff <= row.old_im;

      // a*hi + floor(a*lo / 2^16) is the floored product with the full word.
      m_rr_ff      <= 65'(ar_hr_ff) + 65'(ar_lr_ff >>> 16);
      m_ii_ff      <= 65'(ai_hi_ff) + 65'(ai_li_ff >>> 16);
      m_ri_ff      <= 65'(ar_hi_ff) + 65'(ar_li_ff >>> 16);
      m_ir_ff      <= 65'(ai_hr_ff) + 65'(ai_lr_ff >>> 16);
      e2_old_re_ff <= e1_old_re_ff;
      e2_old_im_ff <= e1_old_im_ff;

      sum_re_ff    <= 67'(m_rr_ff) - 67'(m_ii_ff) + 67'(e2_old_re_ff);
      sum_im_ff    <= 67'(m_ri_ff) + 67'(m_ir_ff) + 67'(e2_old_im_ff);
   end

   assign over_re  = sum_re_ff > SUM_MAX;
   assign under_re = sum_re_ff < SUM_MIN;
   assign over_im  = sum_im_ff > SUM_MAX;
   assign under_im = sum_im_ff < SUM_MIN;

   always_comb begin
      result.result_re = over_re ? WORD_MAX : (under_re ? WORD_MIN : sum_re_ff[31:0]);
      result.result_im = over_im ? WORD_MAX : (under_im ? WORD_MIN : sum_im_ff[31:0]);
      result.saturated = over_re || under_re || over_im || under_im;
   end

   assign push = e3_valid_ff;

endmodule

`default_nettype wire

/* rtl/ccspmv_fifo.sv */
// Result queue with a reservation count: an end-row item claims a slot
// when accepted, so the pipeline never stalls. Depends on ccspmv_pkg.
`default_nettype none

module ccspmv_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   claim,
   input  logic                   push,
   input  ccspmv_pkg::result_type push_data,
   input  logic                   pop,
   output logic                   space,
   output logic                   valid,
   output ccspmv_pkg::result_type head
);
   import ccspmv_pkg::*;

   localparam int PTR_W = $clog2(RSP_DEPTH);

   result_type       mem [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W:0]   count_ff;
   logic [PTR_W:0]   count_in;
   logic [PTR_W:0]   reserve_ff;
   logic [PTR_W:0]   reserve_in;
   logic             pop_fire;

   assign pop_fire   = pop && valid;
   assign count_in   = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop_fire);
   assign reserve_in = reserve_ff + (PTR_W+1)'(claim) - (PTR_W+1)'(pop_fire);

   assign space = reserve_ff < (PTR_W+1)'(RSP_DEPTH);
   assign valid = count_ff != '0;
   assign head  = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
         reserve_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop_fire) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff   <= count_in;
         reserve_ff <= reserve_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/ccspmv_check.sv */
// Port-level checker for the complex CSR SpMV accumulator, bound to the
// top level. Depends on ccspmv_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ccspmv_check (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input ccspmv_pkg::word_type result_re,
   input ccspmv_pkg::word_type result_im,
   input logic                 saturated
);
   import ccspmv_pkg::*;

   // Hold a stalled item.
   `CCSPMV_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `CCSPMV_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(result_re) && $stable(result_im) && $stable(saturated))

   // A flagged item carries a clamped part.
   `CCSPMV_ASSERT(a_sat_clamped, clock, reset, rsp_valid && saturated |-> (result_re == WORD_MAX || result_re == WORD_MIN || result_im == WORD_MAX || result_im == WORD_MIN))

   // Out of reset: queue empty, requests taken.
   `CCSPMV_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid && req_ready)

endmodule

bind complex_csr_spmv_accumulate ccspmv_check u_ccspmv_check (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .result_re (rsp_bus.result_re),
   .result_im (rsp_bus.result_im),
   .saturated (rsp_bus.saturated)
);

`default_nettype wire
